[design/mdpb_pkg.sv]
package mdpb_pkg;

  // Field widths
  localparam int POS_W     = 24;
  localparam int CNT_W     = 16;
  localparam int PIX_CNT_W = 7;
  localparam int PIX_OUT_W = 6;

  // Scaling arithmetic widths
  localparam int PROD_W = POS_W + PIX_CNT_W;
  localparam int NUM_W  = PROD_W + 2;
  localparam int DEN_W  = POS_W + 1;
  localparam int QUO_W  = PIX_CNT_W;

  // Grid size defaults
  localparam int TOP_PIXELS_MAX_DEF    = 64;
  localparam int BOTTOM_PIXELS_MAX_DEF = 64;

  // Configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_TOP_START = 3'd0;
  localparam logic [2:0] REG_TOP_END   = 3'd1;
  localparam logic [2:0] REG_TOP_PIX   = 3'd2;
  localparam logic [2:0] REG_BOT_START = 3'd3;
  localparam logic [2:0] REG_BOT_END   = 3'd4;
  localparam logic [2:0] REG_BOT_PIX   = 3'd5;

  localparam logic [PIX_CNT_W-1:0] PIX_CNT_RESET = 7'd64;

  // Opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Result kinds
  localparam logic KIND_CELL = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0]     top_window_start;
    logic [POS_W-1:0]     top_window_end;
    logic [PIX_CNT_W-1:0] top_pixel_count;
    logic [POS_W-1:0]     bottom_window_start;
    logic [POS_W-1:0]     bottom_window_end;
    logic [PIX_CNT_W-1:0] bottom_pixel_count;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_CHECK,
    ST_T_MUL,
    ST_T_GO,
    ST_T_WAIT,
    ST_B_MUL,
    ST_B_GO,
    ST_B_WAIT,
    ST_CELL_RD,
    ST_CELL_WR,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic latch;
    logic clr_step;
    logic scan_reset;
    logic mul_load;
    logic div_start;
    logic axis_bot;
    logic take_pix;
    logic mem_rd_cell;
    logic mem_wr_cell;
    logic scan_step;
    logic emit_hit;
    logic emit_done;
  } cmd_t;

  typedef struct packed {
    logic in_window;
    logic clr_last;
    logic div_done;
    logic hit;
    logic scan_end;
  } status_t;

endpackage

[design/mdpb_regs.sv]
module mdpb_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mdpb_pkg::ADDR_W-1:0]   paddr,
  input  logic [mdpb_pkg::DATA_W-1:0]   pwdata,
  output logic [mdpb_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output mdpb_pkg::cfg_t                cfg
);

  localparam int DW = mdpb_pkg::DATA_W;
  localparam int PW = mdpb_pkg::POS_W;
  localparam int CW = mdpb_pkg::PIX_CNT_W;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  // Write registers on the access beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.top_window_start    <= '0;
      cfg.top_window_end      <= '0;
      cfg.top_pixel_count     <= mdpb_pkg::PIX_CNT_RESET;
      cfg.bottom_window_start <= '0;
      cfg.bottom_window_end   <= '0;
      cfg.bottom_pixel_count  <= mdpb_pkg::PIX_CNT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        mdpb_pkg::REG_TOP_START: cfg.top_window_start    <= pwdata[PW-1:0];
        mdpb_pkg::REG_TOP_END:   cfg.top_window_end      <= pwdata[PW-1:0];
        mdpb_pkg::REG_TOP_PIX:   cfg.top_pixel_count     <= pwdata[CW-1:0];
        mdpb_pkg::REG_BOT_START: cfg.bottom_window_start <= pwdata[PW-1:0];
        mdpb_pkg::REG_BOT_END:   cfg.bottom_window_end   <= pwdata[PW-1:0];
        mdpb_pkg::REG_BOT_PIX:   cfg.bottom_pixel_count  <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      mdpb_pkg::REG_TOP_START: prdata = DW'(cfg.top_window_start);
      mdpb_pkg::REG_TOP_END:   prdata = DW'(cfg.top_window_end);
      mdpb_pkg::REG_TOP_PIX:   prdata = DW'(cfg.top_pixel_count);
      mdpb_pkg::REG_BOT_START: prdata = DW'(cfg.bottom_window_start);
      mdpb_pkg::REG_BOT_END:   prdata = DW'(cfg.bottom_window_end);
      mdpb_pkg::REG_BOT_PIX:   prdata = DW'(cfg.bottom_pixel_count);
      default:                 prdata = '0;
    endcase
  end

endmodule

[design/mdpb_div.sv]
module mdpb_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mdpb_pkg::NUM_W-1:0]   numer,
  input  logic [mdpb_pkg::DEN_W-1:0]   denom,
  output logic [mdpb_pkg::QUO_W-1:0]   quo,
  output logic                         done
);

  // Restoring division, one quotient bit per cycle. The caller guarantees
  // the quotient fits in QUO_W bits.
  localparam int NW = mdpb_pkg::NUM_W;
  localparam int QW = mdpb_pkg::QUO_W;
  localparam int SW = $clog2(QW);

  logic [NW-1:0] rem;
  logic [NW-1:0] dsh;
  logic [SW-1:0] step_cnt;
  logic          run;
  logic          ge;

  assign ge = (rem >= dsh);

  // Control: step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run      <= 1'b1;
        step_cnt <= '0;
      end else if (run) begin
        step_cnt <= step_cnt + SW'(1);
        if (step_cnt == SW'(QW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: subtract shifted divisor when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= numer;
      dsh <= NW'(denom) << (QW - 1);
      quo <= '0;
    end else if (run) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quo <= {quo[QW-2:0], ge};
      dsh <= dsh >> 1;
    end
  end

endmodule

[design/mdpb_ctrl.sv]
module mdpb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         opcode,
  input  mdpb_pkg::status_t  status,
  output mdpb_pkg::cmd_t     cmd,
  output logic               busy
);

  mdpb_pkg::state_t state;
  mdpb_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mdpb_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mdpb_pkg::ST_INIT: begin
        if (status.clr_last) state_next = mdpb_pkg::ST_IDLE;
      end
      mdpb_pkg::ST_IDLE: begin
        if (start) begin
          unique case (opcode)
            mdpb_pkg::OP_CLEAR:  state_next = mdpb_pkg::ST_CLEAR;
            mdpb_pkg::OP_INSERT: state_next = mdpb_pkg::ST_CHECK;
            mdpb_pkg::OP_READ:   state_next = mdpb_pkg::ST_SCAN;
            default:             state_next = mdpb_pkg::ST_IDLE;
          endcase
        end
      end
      mdpb_pkg::ST_CLEAR: begin
        if (status.clr_last) state_next = mdpb_pkg::ST_IDLE;
      end
      mdpb_pkg::ST_CHECK: begin
        state_next = status.in_window ? mdpb_pkg::ST_T_MUL : mdpb_pkg::ST_IDLE;
      end
      mdpb_pkg::ST_T_MUL: state_next = mdpb_pkg::ST_T_GO;
      mdpb_pkg::ST_T_GO:  state_next = mdpb_pkg::ST_T_WAIT;
      mdpb_pkg::ST_T_WAIT: begin
        if (status.div_done) state_next = mdpb_pkg::ST_B_MUL;
      end
      mdpb_pkg::ST_B_MUL: state_next = mdpb_pkg::ST_B_GO;
      mdpb_pkg::ST_B_GO:  state_next = mdpb_pkg::ST_B_WAIT;
      mdpb_pkg::ST_B_WAIT: begin
        if (status.div_done) state_next = mdpb_pkg::ST_CELL_RD;
      end
      mdpb_pkg::ST_CELL_RD: state_next = mdpb_pkg::ST_CELL_WR;
      mdpb_pkg::ST_CELL_WR: state_next = mdpb_pkg::ST_IDLE;
      mdpb_pkg::ST_SCAN: begin
        if (status.hit || status.scan_end) state_next = mdpb_pkg::ST_IDLE;
      end
      default: state_next = mdpb_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd         = '0;
    busy        = 1'b1;
    unique case (state)
      mdpb_pkg::ST_INIT: begin
        cmd.clr_step = 1'b1;
      end
      mdpb_pkg::ST_IDLE: begin
        busy           = 1'b0;
        cmd.latch      = start;
        cmd.scan_reset = start && (opcode == mdpb_pkg::OP_CLEAR);
      end
      mdpb_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      mdpb_pkg::ST_CHECK: ;
      mdpb_pkg::ST_T_MUL: begin
        cmd.mul_load = 1'b1;
      end
      mdpb_pkg::ST_T_GO: begin
        cmd.div_start = 1'b1;
      end
      mdpb_pkg::ST_T_WAIT: begin
        cmd.take_pix = status.div_done;
      end
      mdpb_pkg::ST_B_MUL: begin
        cmd.axis_bot = 1'b1;
        cmd.mul_load = 1'b1;
      end
      mdpb_pkg::ST_B_GO: begin
        cmd.axis_bot  = 1'b1;
        cmd.div_start = 1'b1;
      end
      mdpb_pkg::ST_B_WAIT: begin
        cmd.axis_bot = 1'b1;
        cmd.take_pix = status.div_done;
      end
      mdpb_pkg::ST_CELL_RD: begin
        cmd.mem_rd_cell = 1'b1;
      end
      mdpb_pkg::ST_CELL_WR: begin
        cmd.mem_wr_cell = 1'b1;
      end
      mdpb_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.emit_hit  = status.hit;
        cmd.emit_done = !status.hit && status.scan_end;
      end
      default: ;
    endcase
  end

  // A cell update always writes back what it read in the cycle before
  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_wr_cell |-> $past(cmd.mem_rd_cell))
    else $error("cell write without preceding cell read");

endmodule

[design/mdpb_dp.sv]
module mdpb_dp #(
  parameter int TOP_PIXELS_MAX    = mdpb_pkg::TOP_PIXELS_MAX_DEF,
  parameter int BOTTOM_PIXELS_MAX = mdpb_pkg::BOTTOM_PIXELS_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mdpb_pkg::cmd_t                    cmd,
  input  mdpb_pkg::cfg_t                    cfg,
  input  logic [mdpb_pkg::POS_W-1:0]        top_position,
  input  logic [mdpb_pkg::POS_W-1:0]        bottom_position,
  input  logic [mdpb_pkg::CNT_W-1:0]        match_count,
  output mdpb_pkg::status_t                 status,
  output logic                              result_valid,
  output logic                              result_kind,
  output logic [mdpb_pkg::PIX_OUT_W-1:0]    top_pixel,
  output logic [mdpb_pkg::PIX_OUT_W-1:0]    bottom_pixel,
  output logic [mdpb_pkg::CNT_W-1:0]        cell_max_count
);

  localparam int PW    = mdpb_pkg::POS_W;
  localparam int CW    = mdpb_pkg::CNT_W;
  localparam int PCW   = mdpb_pkg::PIX_CNT_W;
  localparam int OW    = mdpb_pkg::PIX_OUT_W;
  localparam int PRW   = mdpb_pkg::PROD_W;
  localparam int NW    = mdpb_pkg::NUM_W;
  localparam int DNW   = mdpb_pkg::DEN_W;
  localparam int QW    = mdpb_pkg::QUO_W;
  localparam int TOTAL = TOP_PIXELS_MAX * BOTTOM_PIXELS_MAX;
  localparam int CIW   = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int SAW   = $clog2(TOTAL + 1);
  localparam int TPW   = (TOP_PIXELS_MAX > 1) ? $clog2(TOP_PIXELS_MAX) : 1;
  localparam int BPW   = (BOTTOM_PIXELS_MAX > 1) ? $clog2(BOTTOM_PIXELS_MAX) : 1;
  localparam int TCAP  = (TOP_PIXELS_MAX < 127) ? TOP_PIXELS_MAX : 127;
  localparam int BCAP  = (BOTTOM_PIXELS_MAX < 127) ? BOTTOM_PIXELS_MAX : 127;

  // Latched item
  logic [PW-1:0] tpos_l;
  logic [PW-1:0] bpos_l;
  logic [CW-1:0] cnt_l;

  // Scaling
  logic [PCW-1:0] n_top;
  logic [PCW-1:0] n_bot;
  logic [PCW-1:0] n_sel;
  logic [PW-1:0]  d_sel;
  logic [PW-1:0]  w_sel;
  logic [PRW-1:0] prod;
  logic [PW-1:0]  w_reg;
  logic [NW-1:0]  div_numer;
  logic [DNW-1:0] div_denom;
  logic [QW-1:0]  div_quo;
  logic           div_done;
  logic [QW-1:0]  pix_clamped;
  logic [TPW-1:0] tp_reg;
  logic [BPW-1:0] bp_reg;
  logic [CIW-1:0] cell_idx;

  // Cell memory: {occupied, best count}
  logic [CW:0]    mem [TOTAL];
  logic [CW:0]    rd_data;
  logic [CIW-1:0] mem_raddr;
  logic [CIW-1:0] mem_waddr;
  logic [CW:0]    mem_wdata;
  logic           mem_we;
  logic           rd_occ;
  logic [CW-1:0]  rd_best;
  logic [CW-1:0]  new_best;

  // Clear sweep
  logic [CIW-1:0] clr_ptr;

  // Scan: issue position and the cell whose data is in rd_data
  logic [SAW-1:0] scan_addr;
  logic [TPW-1:0] scan_row;
  logic [BPW-1:0] scan_col;
  logic           chk_valid;
  logic [SAW-1:0] chk_addr;
  logic [TPW-1:0] chk_row;
  logic [BPW-1:0] chk_col;
  logic           at_end;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      tpos_l <= top_position;
      bpos_l <= bottom_position;
      cnt_l  <= match_count;
    end
  end

  // Effective pixel counts: zero acts as one, large values saturate
  always_comb begin
    if (cfg.top_pixel_count == '0) begin
      n_top = PCW'(1);
    end else if (cfg.top_pixel_count > PCW'(TCAP)) begin
      n_top = PCW'(TCAP);
    end else begin
      n_top = cfg.top_pixel_count;
    end
    if (cfg.bottom_pixel_count == '0) begin
      n_bot = PCW'(1);
    end else if (cfg.bottom_pixel_count > PCW'(BCAP)) begin
      n_bot = PCW'(BCAP);
    end else begin
      n_bot = cfg.bottom_pixel_count;
    end
  end

  assign status.in_window = (tpos_l >= cfg.top_window_start) &&
                            (tpos_l <  cfg.top_window_end) &&
                            (bpos_l >= cfg.bottom_window_start) &&
                            (bpos_l <  cfg.bottom_window_end);

  // Select the axis being scaled
  always_comb begin
    if (cmd.axis_bot) begin
      n_sel = n_bot;
      d_sel = bpos_l - cfg.bottom_window_start;
      w_sel = cfg.bottom_window_end - cfg.bottom_window_start;
    end else begin
      n_sel = n_top;
      d_sel = tpos_l - cfg.top_window_start;
      w_sel = cfg.top_window_end - cfg.top_window_start;
    end
  end

  // Offset times pixel count, registered before the divide
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod  <= PRW'(d_sel) * PRW'(n_sel);
      w_reg <= w_sel;
    end
  end

  // Round to nearest: (2*d*n + w) / (2*w)
  assign div_numer = NW'({prod, 1'b0}) + NW'(w_reg);
  assign div_denom = {w_reg, 1'b0};

  mdpb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .numer (div_numer),
    .denom (div_denom),
    .quo   (div_quo),
    .done  (div_done)
  );

  assign status.div_done = div_done;
  assign pix_clamped = (div_quo > (n_sel - PCW'(1))) ? (n_sel - PCW'(1)) : div_quo;

  always_ff @(posedge clk) begin
    if (cmd.take_pix) begin
      if (cmd.axis_bot) begin
        bp_reg <= BPW'(pix_clamped);
      end else begin
        tp_reg <= TPW'(pix_clamped);
      end
    end
  end

  assign cell_idx = CIW'(tp_reg) * CIW'(BOTTOM_PIXELS_MAX) + CIW'(bp_reg);

  // Memory ports
  assign rd_occ    = rd_data[CW];
  assign rd_best   = rd_data[CW-1:0];
  assign new_best  = (!rd_occ || (cnt_l > rd_best)) ? cnt_l : rd_best;
  assign mem_raddr = cmd.mem_rd_cell ? cell_idx : scan_addr[CIW-1:0];
  assign mem_waddr = cmd.clr_step ? clr_ptr : cell_idx;
  assign mem_wdata = cmd.clr_step ? '0 : {1'b1, new_best};
  assign mem_we    = cmd.clr_step | cmd.mem_wr_cell;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[mem_raddr];
  end

  // Sweep the clear pointer over every cell
  assign status.clr_last = (clr_ptr == CIW'(TOTAL - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.clr_step) begin
      clr_ptr <= status.clr_last ? '0 : clr_ptr + CIW'(1);
    end
  end

  // Scan: issue one read per cycle, check the previous one
  assign at_end          = (scan_addr == SAW'(TOTAL));
  assign status.hit      = chk_valid && rd_occ;
  assign status.scan_end = at_end && !chk_valid;

  always_ff @(posedge clk) begin
    if (rst || cmd.scan_reset) begin
      scan_addr <= '0;
      scan_row  <= '0;
      scan_col  <= '0;
      chk_valid <= 1'b0;
    end else if (cmd.scan_step) begin
      if (cmd.emit_hit) begin
        // resume just past the reported cell
        scan_addr <= chk_addr + SAW'(1);
        if (chk_col == BPW'(BOTTOM_PIXELS_MAX - 1)) begin
          scan_col <= '0;
          scan_row <= chk_row + TPW'(1);
        end else begin
          scan_col <= chk_col + BPW'(1);
          scan_row <= chk_row;
        end
        chk_valid <= 1'b0;
      end else if (cmd.emit_done) begin
        scan_addr <= '0;
        scan_row  <= '0;
        scan_col  <= '0;
        chk_valid <= 1'b0;
      end else begin
        chk_valid <= !at_end;
        if (!at_end) begin
          chk_addr  <= scan_addr;
          chk_row   <= scan_row;
          chk_col   <= scan_col;
          scan_addr <= scan_addr + SAW'(1);
          if (scan_col == BPW'(BOTTOM_PIXELS_MAX - 1)) begin
            scan_col <= '0;
            scan_row <= scan_row + TPW'(1);
          end else begin
            scan_col <= scan_col + BPW'(1);
          end
        end
      end
    end else begin
      chk_valid <= 1'b0;
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_hit | cmd.emit_done;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_hit) begin
      result_kind    <= mdpb_pkg::KIND_CELL;
      top_pixel      <= OW'(chk_row);
      bottom_pixel   <= OW'(chk_col);
      cell_max_count <= rd_best;
    end else if (cmd.emit_done) begin
      result_kind    <= mdpb_pkg::KIND_DONE;
      top_pixel      <= '0;
      bottom_pixel   <= '0;
      cell_max_count <= '0;
    end
  end

  // A read item yields one beat, so two beats never come back to back
  a_beat_spacing: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result beats in consecutive cycles");

  a_scan_resume: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_hit && !cmd.scan_reset) |=> scan_addr == $past(chk_addr) + SAW'(1))
    else $error("scan does not resume after the reported cell");

  a_clear_wrap: assert property (@(posedge clk) disable iff (rst)
    (cmd.clr_step && status.clr_last) |=> clr_ptr == '0)
    else $error("clear pointer did not return to zero");

endmodule

[design/match_dot_plot_max_binning_unit.sv]
// Match dot-plot binning unit. Accepts one item when start is high and busy
// is low; busy stays high until the item is finished. An insert runs two
// 7-step restoring divides that share one divider, then a read-modify-write
// of the cell memory; an insert outside the windows is dropped after the
// window check. A read scans the cells in order through the single read
// port of the cell memory until it reaches an occupied cell or the grid end.
// A clear sweeps the cell memory one cell per cycle, covering every one of its
// TOP_PIXELS_MAX*BOTTOM_PIXELS_MAX cells (4096 by default); the same sweep
// runs after reset, during which busy is high. Each read gives exactly one
// result beat on result_valid, one cycle wide; the receiver cannot stall it
// and must take it when it appears. Configuration registers may be written
// over the APB port only while busy is low.
module match_dot_plot_max_binning_unit #(
  parameter int TOP_PIXELS_MAX    = mdpb_pkg::TOP_PIXELS_MAX_DEF,
  parameter int BOTTOM_PIXELS_MAX = mdpb_pkg::BOTTOM_PIXELS_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mdpb_pkg::ADDR_W-1:0]     paddr,
  input  logic [mdpb_pkg::DATA_W-1:0]     pwdata,
  output logic [mdpb_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      opcode,
  input  logic [mdpb_pkg::POS_W-1:0]      top_position,
  input  logic [mdpb_pkg::POS_W-1:0]      bottom_position,
  input  logic [mdpb_pkg::CNT_W-1:0]      match_count,
  output logic                            result_valid,
  output logic                            result_kind,
  output logic [mdpb_pkg::PIX_OUT_W-1:0]  top_pixel,
  output logic [mdpb_pkg::PIX_OUT_W-1:0]  bottom_pixel,
  output logic [mdpb_pkg::CNT_W-1:0]      cell_max_count
);

  mdpb_pkg::cfg_t    cfg;
  mdpb_pkg::cmd_t    cmd;
  mdpb_pkg::status_t status;

  mdpb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mdpb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  mdpb_dp #(
    .TOP_PIXELS_MAX    (TOP_PIXELS_MAX),
    .BOTTOM_PIXELS_MAX (BOTTOM_PIXELS_MAX)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg             (cfg),
    .top_position    (top_position),
    .bottom_position (bottom_position),
    .match_count     (match_count),
    .status          (status),
    .result_valid    (result_valid),
    .result_kind     (result_kind),
    .top_pixel       (top_pixel),
    .bottom_pixel    (bottom_pixel),
    .cell_max_count  (cell_max_count)
  );

endmodule

[dv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mdpb_pkg::*;

  localparam int GRID_COLS = BOTTOM_PIXELS_MAX_DEF;
  localparam int GRID_CELLS = TOP_PIXELS_MAX_DEF * BOTTOM_PIXELS_MAX_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1050;
  localparam int SETTLE_CYCLES = 30;
  localparam int DRAIN_LIMIT = 20000;
  localparam longint RUN_LIMIT_NS = 20_000_000;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef struct packed {
    logic                 kind;
    logic [PIX_OUT_W-1:0] top_pix;
    logic [PIX_OUT_W-1:0] bot_pix;
    logic [CNT_W-1:0]     best;
  } cell_report_t;

  localparam cell_report_t NO_REPORT = '0;
  localparam cell_report_t DONE_REPORT = '{KIND_DONE, 6'd0, 6'd0, 16'h0};

  // ROW_REG rows carry the register value in top_pos
  typedef enum logic [1:0] {ROW_ITEM, ROW_CHECK, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [2:0]       reg_idx;
    logic [1:0]       op;
    logic [POS_W-1:0] top_pos;
    logic [POS_W-1:0] bot_pos;
    logic [CNT_W-1:0] count;
    cell_report_t     report;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 35;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // reset windows are empty: nothing binned, reads end at once
    '{ROW_CHECK, REG_TOP_START, OP_READ, 24'h0, 24'h0, 16'h0, DONE_REPORT},
    '{ROW_ITEM, REG_TOP_START, OP_INSERT, 24'h0, 24'h0, 16'h5, NO_REPORT},
    '{ROW_CHECK, REG_TOP_START, OP_READ, 24'h0, 24'h0, 16'h0, DONE_REPORT},
    // full windows, corner cells, max kept, unused opcode ignored
    '{ROW_REG, REG_TOP_END, OP_CLEAR, 24'hFFFFFF, 24'h0, 16'h0, NO_REPORT},
    '{ROW_REG, REG_BOT_END, OP_CLEAR, 24'hFFFFFF, 24'h0, 16'h0, NO_REPORT},
    '{ROW_ITEM, REG_TOP_START, OP_INSERT, 24'h0, 24'h0, 16'hFFFF, NO_REPORT},
    '{ROW_ITEM, REG_TOP_START, OP_INSERT, 24'hFFFFFE, 24'hFFFFFE, 16'h0, NO_REPORT},
    '{ROW_ITEM, REG_TOP_START, OP_INSERT, 24'h0, 24'h0, 16'h1, NO_REPORT},
    '{ROW_ITEM, REG_TOP_START, OP_UNUSED, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, NO_REPORT},
    '{ROW_CHECK, REG_TOP_START, OP_READ, 24'h0, 24'h0, 16'h0,
      '{KIND_CELL, 6'd0, 6'd0, 16'hFFFF}},
    '{ROW_CHECK, REG_TOP_START, OP_READ, 24'h0, 24'h0, 16'h0,
      '{KIND_CELL, 6'd63, 6'd63, 16'h0}},
    '{ROW_CHECK, REG_TOP_START, OP_READ, 24'h0, 24'h0, 16'h0, DONE_REPORT},
    // zero count acts as one, oversize count saturates; old cells survive
    '{ROW_REG, REG_TOP_PIX, OP_CLEAR, 24'd0, 24'h0, 16'h0, NO_REPORT},
    '{ROW_REG, REG_BOT_PIX, OP_CLEAR, 24'd127, 24'h0, 16'h0, NO_REPORT},
    '{ROW_ITEM, REG_TOP_START, OP_INSERT, 24'h800000, 24'h400000, 16'h7, NO_REPORT},
    '{ROW_CHECK, REG_TOP_START, OP_READ, 24'h0, 24'h0, 16'h0,
      '{KIND_CELL, 6'd0, 6'd0, 16'hFFFF}},
    // insert in the middle of a scan, read on, then clear before the scan ends
    '{ROW_ITEM, REG_TOP_START, OP_INSERT, 24'h0, 24'hFFFFFE, 16'h3, NO_REPORT},
    '{ROW_ITEM, REG_TOP_START, OP_READ, 24'h0, 24'h0, 16'h0, NO_REPORT},
    '{ROW_ITEM, REG_TOP_START, OP_READ, 24'h0, 24'h0, 16'h0, NO_REPORT},
    '{ROW_ITEM, REG_TOP_START, OP_CLEAR, 24'h0, 24'h0, 16'h0, NO_REPORT},
    '{ROW_CHECK, REG_TOP_START, OP_READ, 24'h0, 24'h0, 16'h0, DONE_REPORT},
    // inverted top window drops the insert
    '{ROW_REG, REG_TOP_START, OP_CLEAR, 24'd20, 24'h0, 16'h0, NO_REPORT},
    '{ROW_REG, REG_TOP_END, OP_CLEAR, 24'd10, 24'h0, 16'h0, NO_REPORT},
    '{ROW_REG, REG_TOP_PIX, OP_CLEAR, 24'd2, 24'h0, 16'h0, NO_REPORT},
    '{ROW_ITEM, REG_TOP_START, OP_INSERT, 24'd25, 24'h0, 16'h3, NO_REPORT},
    // width 4 over 2 pixels: half rounds up, top of range clamps, edges
    '{ROW_REG, REG_TOP_START, OP_CLEAR, 24'd10, 24'h0, 16'h0, NO_REPORT},
    '{ROW_REG, REG_TOP_END, OP_CLEAR, 24'd14, 24'h0, 16'h0, NO_REPORT},
    '{ROW_ITEM, REG_TOP_START, OP_INSERT, 24'd11, 24'h0, 16'h9, NO_REPORT},
    '{ROW_ITEM, REG_TOP_START, OP_INSERT, 24'd13, 24'h0, 16'h4, NO_REPORT},
    '{ROW_ITEM, REG_TOP_START, OP_INSERT, 24'd10, 24'd5, 16'h2, NO_REPORT},
    '{ROW_ITEM, REG_TOP_START, OP_INSERT, 24'd14, 24'h0, 16'hFFFF, NO_REPORT},
    '{ROW_ITEM, REG_TOP_START, OP_INSERT, 24'd9, 24'h0, 16'hFFFF, NO_REPORT},
    '{ROW_CHECK, REG_TOP_START, OP_READ, 24'h0, 24'h0, 16'h0,
      '{KIND_CELL, 6'd0, 6'd0, 16'h2}},
    '{ROW_CHECK, REG_TOP_START, OP_READ, 24'h0, 24'h0, 16'h0,
      '{KIND_CELL, 6'd1, 6'd0, 16'h9}},
    '{ROW_CHECK, REG_TOP_START, OP_READ, 24'h0, 24'h0, 16'h0, DONE_REPORT}
  };

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 start;
  logic                 busy;
  logic [1:0]           opcode;
  logic [POS_W-1:0]     top_position;
  logic [POS_W-1:0]     bottom_position;
  logic [CNT_W-1:0]     match_count;
  logic                 result_valid;
  logic                 result_kind;
  logic [PIX_OUT_W-1:0] top_pixel;
  logic [PIX_OUT_W-1:0] bottom_pixel;
  logic [CNT_W-1:0]     cell_max_count;

  // Shadow of the block: registers, grid and scan pointer
  cfg_t             shadow_cfg;
  bit               grid_taken [GRID_CELLS];
  logic [CNT_W-1:0] grid_best [GRID_CELLS];
  int unsigned      scan_pos;
  cell_report_t     pending_reports [$];

  bit steady_phase;
  int mismatch_count;
  int beats_checked;
  int items_done;
  int inserts_binned;
  int reads_sent;
  int scans_done;
  int clears_sent;
  int settings_used;

  match_dot_plot_max_binning_unit dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .top_position(top_position),
    .bottom_position(bottom_position),
    .match_count(match_count),
    .result_valid(result_valid),
    .result_kind(result_kind),
    .top_pixel(top_pixel),
    .bottom_pixel(bottom_pixel),
    .cell_max_count(cell_max_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout at %0t with %0d results outstanding", $realtime,
             pending_reports.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic int unsigned axis_pixels(input logic [PIX_CNT_W-1:0] n,
                                              input int unsigned limit);
    if (n == 0) return 1;
    if (n > limit) return limit;
    return n;
  endfunction

  // Round d*n/w to nearest with halves up, then clamp to the last pixel
  function automatic int unsigned axis_pixel(input logic [POS_W-1:0] pos,
                                             input logic [POS_W-1:0] lo,
                                             input logic [POS_W-1:0] hi,
                                             input int unsigned n);
    longint unsigned d;
    longint unsigned w;
    longint unsigned p;
    d = pos - lo;
    w = hi - lo;
    p = (2 * d * n + w) / (2 * w);
    if (p > n - 1) p = n - 1;
    return int'(p);
  endfunction

  // Advance the shadow grid by one item; return 1 when a result is due
  function automatic bit predict_grid(input logic [1:0] op,
                                      input logic [POS_W-1:0] tpos,
                                      input logic [POS_W-1:0] bpos,
                                      input logic [CNT_W-1:0] cnt,
                                      output cell_report_t rep,
                                      output bit binned);
    int unsigned tp;
    int unsigned bp;
    int unsigned idx;
    int unsigned i;
    rep = NO_REPORT;
    binned = 1'b0;
    case (op)
      OP_CLEAR: begin
        foreach (grid_taken[k]) grid_taken[k] = 1'b0;
        scan_pos = 0;
        return 1'b0;
      end
      OP_INSERT: begin
        if (tpos < shadow_cfg.top_window_start || tpos >= shadow_cfg.top_window_end)
          return 1'b0;
        if (bpos < shadow_cfg.bottom_window_start ||
            bpos >= shadow_cfg.bottom_window_end)
          return 1'b0;
        tp = axis_pixel(tpos, shadow_cfg.top_window_start, shadow_cfg.top_window_end,
                        axis_pixels(shadow_cfg.top_pixel_count, TOP_PIXELS_MAX_DEF));
        bp = axis_pixel(bpos, shadow_cfg.bottom_window_start,
                        shadow_cfg.bottom_window_end,
                        axis_pixels(shadow_cfg.bottom_pixel_count, BOTTOM_PIXELS_MAX_DEF));
        idx = tp * GRID_COLS + bp;
        binned = 1'b1;
        if (!grid_taken[idx]) begin
          grid_taken[idx] = 1'b1;
          grid_best[idx] = cnt;
        end else if (cnt > grid_best[idx]) begin
          grid_best[idx] = cnt;
        end
        return 1'b0;
      end
      OP_READ: begin
        for (i = scan_pos; i < GRID_CELLS; i++) begin
          if (grid_taken[i]) begin
            rep.kind = KIND_CELL;
            rep.top_pix = PIX_OUT_W'(i / GRID_COLS);
            rep.bot_pix = PIX_OUT_W'(i % GRID_COLS);
            rep.best = grid_best[i];
            scan_pos = i + 1;
            return 1'b1;
          end
        end
        rep = DONE_REPORT;
        scan_pos = 0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int idle_gap();
    int unsigned r;
    if (steady_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Present one item, hold it until taken, then predict and tally it
  task automatic issue_item(input logic [1:0] op, input logic [POS_W-1:0] tpos,
                            input logic [POS_W-1:0] bpos, input logic [CNT_W-1:0] cnt,
                            input bit use_typed, input cell_report_t typed,
                            output bit scan_over);
    cell_report_t rep;
    bit has_rep;
    bit binned;
    int gap;
    start <= 1'b1;
    opcode <= op;
    top_position <= tpos;
    bottom_position <= bpos;
    match_count <= cnt;
    do @(posedge clk); while (busy);
    has_rep = predict_grid(op, tpos, bpos, cnt, rep, binned);
    scan_over = has_rep && rep.kind == KIND_DONE;
    if (has_rep) pending_reports.push_back(use_typed ? typed : rep);
    if (op == OP_CLEAR) clears_sent++;
    if (op == OP_READ) reads_sent++;
    if (binned) inserts_binned++;
    if (scan_over) scans_done++;
    if (op == OP_CLEAR || op == OP_READ || binned) items_done++;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start, collect outstanding results, and wait for the block to go idle
  task automatic settle_block();
    int unsigned waited;
    waited = 0;
    start <= 1'b0;
    while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_reports.size() != 0) begin
      flag_mismatch($sformatf("%0d read results never arrived", pending_reports.size()));
      pending_reports.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Setup then access cycle; mirror the write into the shadow registers
  task automatic reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TOP_START: shadow_cfg.top_window_start = val[POS_W-1:0];
      REG_TOP_END:   shadow_cfg.top_window_end = val[POS_W-1:0];
      REG_TOP_PIX:   shadow_cfg.top_pixel_count = val[PIX_CNT_W-1:0];
      REG_BOT_START: shadow_cfg.bottom_window_start = val[POS_W-1:0];
      REG_BOT_END:   shadow_cfg.bottom_window_end = val[POS_W-1:0];
      REG_BOT_PIX:   shadow_cfg.bottom_pixel_count = val[PIX_CNT_W-1:0];
      default: ;
    endcase
  endtask

  // Empty, inverted, full, narrow or wide window
  task automatic pick_window(output logic [POS_W-1:0] lo, output logic [POS_W-1:0] hi);
    int unsigned r;
    int unsigned w;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      lo = $urandom_range(0, 1) ? POS_MAX : POS_W'($urandom());
      hi = $urandom_range(0, lo);
    end else if (r < 20) begin
      lo = '0;
      hi = POS_MAX;
    end else begin
      w = (r < 60) ? $urandom_range(1, 200) : $urandom_range(1, POS_MAX);
      lo = $urandom_range(0, POS_MAX - w);
      hi = lo + w;
    end
  endtask

  function automatic logic [PIX_CNT_W-1:0] pick_pixels();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return $urandom_range(65, 127);
    if (r < 30) return 1;
    if (r < 40) return 64;
    return $urandom_range(1, 64);
  endfunction

  // Mostly inside the window, sometimes anywhere in the 24-bit range
  function automatic logic [POS_W-1:0] pick_pos(input logic [POS_W-1:0] lo,
                                                input logic [POS_W-1:0] hi);
    if (hi > lo && $urandom_range(0, 99) < 85)
      return lo + $urandom_range(0, hi - lo - 1);
    return POS_W'($urandom());
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    return CNT_W'($urandom());
  endfunction

  // One register setting: program, fill the grid, then read it out to the end
  task automatic run_random_phase();
    logic [POS_W-1:0] tlo;
    logic [POS_W-1:0] thi;
    logic [POS_W-1:0] blo;
    logic [POS_W-1:0] bhi;
    int unsigned n_items;
    int unsigned r;
    bit scan_over;
    settle_block();
    pick_window(tlo, thi);
    pick_window(blo, bhi);
    reg_write(REG_TOP_START, DATA_W'(tlo));
    reg_write(REG_TOP_END, DATA_W'(thi));
    reg_write(REG_TOP_PIX, DATA_W'(pick_pixels()));
    reg_write(REG_BOT_START, DATA_W'(blo));
    reg_write(REG_BOT_END, DATA_W'(bhi));
    reg_write(REG_BOT_PIX, DATA_W'(pick_pixels()));
    settings_used++;
    steady_phase = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) < 7)
      issue_item(OP_CLEAR, POS_W'($urandom()), POS_W'($urandom()), pick_count(),
                 1'b0, NO_REPORT, scan_over);
    n_items = $urandom_range(15, 50);
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 80)
        issue_item(OP_INSERT, pick_pos(tlo, thi), pick_pos(blo, bhi), pick_count(),
                   1'b0, NO_REPORT, scan_over);
      else if (r < 92)
        issue_item(OP_READ, POS_W'($urandom()), POS_W'($urandom()), pick_count(),
                   1'b0, NO_REPORT, scan_over);
      else if (r < 95)
        issue_item(OP_CLEAR, POS_W'($urandom()), POS_W'($urandom()), pick_count(),
                   1'b0, NO_REPORT, scan_over);
      else
        issue_item(OP_UNUSED, POS_W'($urandom()), POS_W'($urandom()), pick_count(),
                   1'b0, NO_REPORT, scan_over);
    end
    do
      issue_item(OP_READ, POS_W'($urandom()), POS_W'($urandom()), pick_count(),
                 1'b0, NO_REPORT, scan_over);
    while (!scan_over);
  endtask

  // Check each result beat against the oldest expectation
  always @(negedge clk) begin
    cell_report_t want;
    if (!rst && result_valid !== 1'b0) begin
      beats_checked++;
      if (pending_reports.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: kind %0d top %0d bottom %0d count %0d",
                                result_kind, top_pixel, bottom_pixel, cell_max_count));
      end else begin
        want = pending_reports.pop_front();
        if (result_kind !== want.kind)
          flag_mismatch($sformatf("result_kind %0d, expected %0d", result_kind, want.kind));
        if (top_pixel !== want.top_pix)
          flag_mismatch($sformatf("top_pixel %0d, expected %0d", top_pixel, want.top_pix));
        if (bottom_pixel !== want.bot_pix)
          flag_mismatch($sformatf("bottom_pixel %0d, expected %0d", bottom_pixel,
                                  want.bot_pix));
        if (cell_max_count !== want.best)
          flag_mismatch($sformatf("cell_max_count %0d, expected %0d", cell_max_count,
                                  want.best));
      end
    end
  end

  initial begin
    stim_row_t row;
    bit scan_over;
    int random_base;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    start <= 1'b0;
    opcode <= OP_CLEAR;
    top_position <= '0;
    bottom_position <= '0;
    match_count <= '0;
    shadow_cfg = '0;
    shadow_cfg.top_pixel_count = PIX_CNT_RESET;
    shadow_cfg.bottom_pixel_count = PIX_CNT_RESET;
    foreach (grid_taken[k]) grid_taken[k] = 1'b0;
    scan_pos = 0;
    steady_phase = 1'b0;

    // Hold reset, then wait out the clearing sweep
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (busy);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) begin
        settle_block();
        reg_write(row.reg_idx, DATA_W'(row.top_pos));
      end else begin
        issue_item(row.op, row.top_pos, row.bot_pos, row.count, row.kind == ROW_CHECK,
                   row.report, scan_over);
      end
    end
    settings_used++;

    // Random phases until enough effective items have gone in
    random_base = items_done;
    while (items_done - random_base < RANDOM_ITEMS) run_random_phase();
    settle_block();

    $display("Covered %0d items over %0d register settings: %0d binned inserts, %0d clears",
             items_done, settings_used, inserts_binned, clears_sent);
    $display("Checked %0d result beats from %0d reads (%0d scan ends), %0d mismatches",
             beats_checked, reads_sent, scans_done, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[match_dot_plot_max_binning_unit.f]
design/mdpb_pkg.sv
design/mdpb_regs.sv
design/mdpb_div.sv
design/mdpb_ctrl.sv
design/mdpb_dp.sv
design/match_dot_plot_max_binning_unit.sv
dv/tb_top.sv
